>>> rtl/core/sbcf_pkg.sv
package sbcf_pkg;

	localparam int MAX_SERVOS = 40;
	localparam int QUEUE_DEPTH = 2;

	// Frame kind codes held in the frame_kind register.
	localparam logic [1:0] KIND_WRITE    = 2'd0;
	localparam logic [1:0] KIND_POSITION = 2'd1;
	localparam logic [1:0] KIND_READ     = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_FRAME_KIND    = 3'd0;
	localparam logic [2:0] REG_DATA_LENGTH   = 3'd1;
	localparam logic [2:0] REG_SERVO_COUNT   = 3'd2;
	localparam logic [2:0] REG_REGISTER_ADDR = 3'd3;
	localparam logic [2:0] REG_MOVE_TIME     = 3'd4;

	localparam logic [7:0] CMD_WRITE    = 8'h04;
	localparam logic [7:0] CMD_POSITION = 8'h06;
	localparam logic [7:0] CMD_READ     = 8'h03;
	localparam logic [7:0] OPTION_BYTE  = 8'h00;
	localparam logic [7:0] READ_LENGTH  = 8'h07;
	localparam logic [7:0] HEADER_BASE  = 8'h06;

	typedef struct packed {
		logic [7:0]  servo_id;
		logic [15:0] servo_value;
	} item_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} beat_t;

	typedef struct packed {
		logic [1:0]  frame_kind;
		logic [1:0]  data_length;
		logic [5:0]  servo_count;
		logic [7:0]  register_address;
		logic [15:0] move_time;
	} cfg_t;

	// One classified servo item waiting for the byte sequencer.
	typedef struct packed {
		logic [1:0]  kind;
		logic        hdr;
		logic        trl;
		logic        len2;
		logic [7:0]  servo_id;
		logic [15:0] servo_value;
		logic [7:0]  len_byte;
		logic [5:0]  cnt;
	} job_t;

endpackage

>>> rtl/core/sbcf_queue.sv
module sbcf_queue #(
	parameter int DEPTH = sbcf_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  sbcf_pkg::job_t     push_job,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output sbcf_pkg::job_t     head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	sbcf_pkg::job_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop && !empty) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |=> full && $stable(wr_ptr_q))
		else $error("write pointer moved while full");

endmodule

>>> rtl/core/sbcf_front.sv
module sbcf_front (
	input  logic              clk,
	input  logic              arst_n,
	input  sbcf_pkg::cfg_t    cfg,
	input  logic              item_valid,
	output logic              item_ready,
	input  sbcf_pkg::item_t   item,
	input  logic              q_full,
	output logic              q_push,
	output sbcf_pkg::job_t    q_job
);

	logic [5:0] servo_index_q;
	logic [5:0] cnt;
	logic       len2;
	logic       accept;
	logic       is_read;
	logic       is_frame;
	logic       trl;

	always_comb begin
		if (cfg.servo_count == 6'd0) begin
			cnt = 6'd1;
		end else if ({1'b0, cfg.servo_count} > 7'(sbcf_pkg::MAX_SERVOS)) begin
			cnt = 6'(sbcf_pkg::MAX_SERVOS);
		end else begin
			cnt = cfg.servo_count;
		end
	end

	assign len2     = cfg.data_length[1];
	assign is_read  = (cfg.frame_kind == sbcf_pkg::KIND_READ);
	assign is_frame = (cfg.frame_kind == sbcf_pkg::KIND_WRITE) ||
	                  (cfg.frame_kind == sbcf_pkg::KIND_POSITION);
	// The item closes the frame once the taken count reaches the effective count.
	assign trl      = ({1'b0, servo_index_q} + 7'd1) >= {1'b0, cnt};

	assign item_ready = !q_full;
	assign accept     = item_valid && item_ready;
	assign q_push     = accept && (is_read || is_frame);

	always_comb begin
		q_job             = '0;
		q_job.kind        = cfg.frame_kind;
		q_job.hdr         = is_read || (servo_index_q == 6'd0);
		q_job.trl         = is_read || trl;
		q_job.len2        = len2;
		q_job.servo_id    = item.servo_id;
		q_job.servo_value = item.servo_value;
		q_job.len_byte    = sbcf_pkg::HEADER_BASE + {1'b0, cnt, 1'b0} +
		                    (len2 ? {2'b00, cnt} : 8'd0);
		q_job.cnt         = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servo_index_q <= '0;
		end else if (accept) begin
			if (is_read) begin
				servo_index_q <= '0;
			end else if (is_frame) begin
				servo_index_q <= trl ? 6'd0 : servo_index_q + 6'd1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into full queue");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_read |=> servo_index_q == 6'd0)
		else $error("read request left frame open");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_frame |=> servo_index_q < 6'd63)
		else $error("servo index ran past count");

endmodule

>>> rtl/core/sbcf_back.sv
module sbcf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sbcf_pkg::cfg_t    cfg,
	input  logic              q_empty,
	input  sbcf_pkg::job_t    q_head,
	output logic              q_pop,
	output logic              frame_valid,
	input  logic              frame_ready,
	output sbcf_pkg::beat_t   frame
);

	typedef enum logic [8:0] {
		ST_LEN = 9'b000000001,
		ST_CMD = 9'b000000010,
		ST_OPT = 9'b000000100,
		ST_ID  = 9'b000001000,
		ST_LO  = 9'b000010000,
		ST_HI  = 9'b000100000,
		ST_T0  = 9'b001000000,
		ST_T1  = 9'b010000000,
		ST_CHK = 9'b100000000
	} step_t;

	step_t           step_q;
	step_t           cur;
	step_t           nxt;
	logic            active_q;
	logic [7:0]      sum_q;
	logic            out_valid_q;
	sbcf_pkg::beat_t out_q;
	logic            fire;
	logic            last;
	logic            is_read;
	logic            is_pos;
	logic [7:0]      byte_val;

	assign is_read = (q_head.kind == sbcf_pkg::KIND_READ);
	assign is_pos  = (q_head.kind == sbcf_pkg::KIND_POSITION);
	assign cur     = active_q ? step_q : (q_head.hdr ? ST_LEN : ST_ID);
	// A new beat moves into the output register when a job waits and the register is free or being taken.
	assign fire    = !q_empty && (!out_valid_q || frame_ready);
	assign q_pop   = fire && last;

	always_comb begin
		nxt      = cur;
		last     = 1'b0;
		byte_val = 8'h00;
		case (cur)
			ST_LEN: begin
				nxt      = ST_CMD;
				byte_val = is_read ? sbcf_pkg::READ_LENGTH : q_head.len_byte;
			end
			ST_CMD: begin
				nxt = ST_OPT;
				if (is_read) begin
					byte_val = sbcf_pkg::CMD_READ;
				end else if (is_pos) begin
					byte_val = sbcf_pkg::CMD_POSITION;
				end else begin
					byte_val = sbcf_pkg::CMD_WRITE;
				end
			end
			ST_OPT: begin
				nxt      = ST_ID;
				byte_val = sbcf_pkg::OPTION_BYTE;
			end
			ST_ID: begin
				nxt      = is_read ? ST_T0 : ST_LO;
				byte_val = q_head.servo_id;
			end
			ST_LO: begin
				nxt      = q_head.len2 ? ST_HI : ST_T0;
				last     = !q_head.len2 && !q_head.trl;
				byte_val = q_head.servo_value[7:0];
			end
			ST_HI: begin
				nxt      = ST_T0;
				last     = !q_head.trl;
				byte_val = q_head.servo_value[15:8];
			end
			ST_T0: begin
				nxt      = ST_T1;
				byte_val = is_pos ? cfg.move_time[7:0] : cfg.register_address;
			end
			ST_T1: begin
				nxt = ST_CHK;
				if (is_read) begin
					byte_val = {6'b000000, cfg.data_length};
				end else if (is_pos) begin
					byte_val = cfg.move_time[15:8];
				end else begin
					byte_val = {2'b00, q_head.cnt};
				end
			end
			ST_CHK: begin
				nxt      = ST_LEN;
				last     = 1'b1;
				byte_val = sum_q;
			end
			default: begin
				nxt      = ST_LEN;
				last     = 1'b1;
				byte_val = 8'h00;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= ST_LEN;
			active_q    <= 1'b0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				active_q    <= !last;
				step_q      <= nxt;
				if (cur == ST_LEN) begin
					sum_q <= byte_val;
				end else if (cur == ST_CHK) begin
					sum_q <= '0;
				end else begin
					sum_q <= sum_q + byte_val;
				end
			end else if (frame_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.frame_byte <= byte_val;
			out_q.frame_end  <= (cur == ST_CHK);
		end
	end

	assign frame_valid = out_valid_q;
	assign frame       = out_q;

	a_active_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !q_empty)
		else $error("job left the queue mid sequence");

	a_chk_ends: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cur == ST_CHK |=> out_valid_q && out_q.frame_end && !active_q)
		else $error("checksum beat not marked as frame end");

	a_data_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cur != ST_CHK |=> !out_q.frame_end)
		else $error("frame end on a data beat");

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> fire && (cur == ST_CHK || cur == ST_LO || cur == ST_HI))
		else $error("job popped at an odd step");

endmodule

>>> rtl/core/servo_bus_command_framer.sv
// Channel   Signals                                    Carries
// --------  -----------------------------------------  -----------------------------
// item      item_valid, item_ready, item               servo id and value, one beat
// frame     frame_valid, frame_ready, frame            frame byte and frame end flag
// config    cfg_we, cfg_index, cfg_data                register writes, no wait
//
// Each item yields two to nine byte beats, or none while the frame kind is the unused code;
// the byte sequencer sends one beat per cycle while a job waits and the frame side takes every beat.
// Items enter the queue in one cycle each until QUEUE_DEPTH classified items wait.
// A stall on the frame side holds the output register; the queue fills, then item_ready drops.
// Reset clears the registers to their defaults, the frame index and the queue.
module servo_bus_command_framer #(
	parameter int QUEUE_DEPTH = sbcf_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  sbcf_pkg::item_t   item,
	output logic              frame_valid,
	input  logic              frame_ready,
	output sbcf_pkg::beat_t   frame,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	sbcf_pkg::cfg_t cfg_q;
	sbcf_pkg::job_t push_job;
	sbcf_pkg::job_t head_job;
	logic           q_push;
	logic           q_pop;
	logic           q_full;
	logic           q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_kind       <= sbcf_pkg::KIND_WRITE;
			cfg_q.data_length      <= 2'd2;
			cfg_q.servo_count      <= 6'd1;
			cfg_q.register_address <= 8'h00;
			cfg_q.move_time        <= 16'h0000;
		end else if (cfg_we) begin
			case (cfg_index)
				sbcf_pkg::REG_FRAME_KIND:    cfg_q.frame_kind       <= cfg_data[1:0];
				sbcf_pkg::REG_DATA_LENGTH:   cfg_q.data_length      <= cfg_data[1:0];
				sbcf_pkg::REG_SERVO_COUNT:   cfg_q.servo_count      <= cfg_data[5:0];
				sbcf_pkg::REG_REGISTER_ADDR: cfg_q.register_address <= cfg_data[7:0];
				sbcf_pkg::REG_MOVE_TIME:     cfg_q.move_time        <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sbcf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_job      (push_job)
	);

	sbcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (head_job)
	);

	sbcf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_empty     (q_empty),
		.q_head      (head_job),
		.q_pop       (q_pop),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame)
	);

endmodule
